// ===== rtl/core/sst_pkg.sv =====
// shared types, character codes and helpers for the style-sheet tokenizer
`default_nettype none

package sst_pkg;

  // input item kinds
  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_END  = 1'b1
  } kind_e;

  // token event codes
  typedef enum logic [2:0] {
    EV_NAME   = 3'd0,
    EV_OPEN   = 3'd1,
    EV_KEY    = 3'd2,
    EV_VALUE  = 3'd3,
    EV_COMMIT = 3'd4,
    EV_CLOSE  = 3'd5,
    EV_END    = 3'd6
  } event_e;

  // character codes
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // event queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // events caused by one input item; only the first can carry a character
  typedef struct packed {
    logic [1:0] cnt;
    event_e     ev0;
    event_e     ev1;
    event_e     ev2;
    logic [7:0] ch;
  } bundle_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/style_sheet_tokenizer.sv =====
// top level of the style-sheet tokenizer: front end, event queue, back end
//
// The slave stream carries one text byte per transfer (s_tdata_i) with
// s_tuser_i low; a transfer with s_tuser_i high marks end of text, flushes
// the held lookahead byte, emits the end event and returns to the reset state.
// The master stream carries one token event per transfer: the event code in
// m_tuser_o, the character (or zero) in m_tdata_o, and m_tlast_o on the
// final event caused by one input transfer. Bytes that cause no event give
// no output transfer.
// One byte is held back as lookahead, so a byte's events appear when the
// next byte (or the end mark) arrives; the first event then passes through the
// event queue and the output register. Input is taken one byte per cycle;
// the back end sends one event per cycle, so items with two or three events
// use the four-entry event queue, and s_tready_o drops only while it is full.
// When the receiver stalls, the output register holds its event and the
// queue fills before the input side backs up.
// Reset clears the parse state, the lookahead byte and the queue.
`default_nettype none

module style_sheet_tokenizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [7:0]  s_tdata_i,   // [7:0] char_in
  input  wire logic        s_tuser_i,   // [0] kind
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [7:0]       m_tdata_o,   // [7:0] char_out
  output logic [2:0]       m_tuser_o,   // [2:0] event_res
  output logic             m_tlast_o    // last
);
  import sst_pkg::*;

  logic    push, full, pop, empty;
  bundle_t push_data, head;

  sst_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_tvalid_i),
    .ready_o  (s_tready_o),
    .kind_i   (s_tuser_i),
    .char_i   (s_tdata_i),
    .q_full_i (full),
    .push_o   (push),
    .bundle_o (push_data)
  );

  sst_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  sst_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head),
    .pop_o      (pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sst_front.sv =====
// front end: accepts bytes, keeps the lookahead byte and parse state, builds event bundles
`default_nettype none

module sst_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire logic            kind_i,
  input  wire logic [7:0]      char_i,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output sst_pkg::bundle_t     bundle_o
);
  import sst_pkg::*;

  typedef enum logic [2:0] {
    ST_OUT   = 3'd0,
    ST_LINE  = 3'd1,
    ST_BLOCK = 3'd2,
    ST_NAME  = 3'd3,
    ST_KEY   = 3'd4,
    ST_PRE   = 3'd5,
    ST_VAL   = 3'd6
  } state_e;

  state_e     st_q, st_d, h_st;
  logic [7:0] held_q, held_d;
  logic       held_vld_q, held_vld_d;
  logic       accept, has_next, took;
  logic [1:0] h_cnt;
  event_e     h_ev0, h_ev1;
  logic [7:0] h_ch;
  bundle_t    b;

  assign ready_o  = !q_full_i;
  assign accept   = valid_i && ready_o;
  assign has_next = (kind_i == KIND_BYTE);

  // handle the held byte with the incoming byte as lookahead
  always_comb begin
    h_st  = st_q;
    h_cnt = 2'd0;
    h_ev0 = EV_NAME;
    h_ev1 = EV_NAME;
    h_ch  = 8'd0;
    took  = 1'b0;
    unique case (st_q)
      ST_OUT: begin
        if (held_q == CH_SLASH && has_next && char_i == CH_SLASH) begin
          h_st = ST_LINE;
          took = 1'b1;
        end else if (held_q == CH_SLASH && has_next && char_i == CH_STAR) begin
          h_st = ST_BLOCK;
          took = 1'b1;
        end else if (!is_ws(held_q)) begin
          h_cnt = 2'd1;
          h_ev0 = EV_NAME;
          h_ch  = held_q;
          h_st  = ST_NAME;
        end
      end
      ST_LINE: begin
        if (held_q == CH_LF) h_st = ST_OUT;
      end
      ST_BLOCK: begin
        if (held_q == CH_STAR && has_next && char_i == CH_SLASH) begin
          h_st = ST_OUT;
          took = 1'b1;
        end
      end
      ST_NAME: begin
        if (is_ws(held_q)) begin
          h_st = ST_NAME;
        end else if (held_q == CH_LBRACE) begin
          h_cnt = 2'd1;
          h_ev0 = EV_OPEN;
          h_st  = ST_KEY;
        end else begin
          h_cnt = 2'd1;
          h_ev0 = EV_NAME;
          h_ch  = held_q;
        end
      end
      ST_KEY: begin
        if (is_ws(held_q)) begin
          h_st = ST_KEY;
        end else if (held_q == CH_COLON) begin
          h_st = ST_PRE;
        end else if (held_q == CH_RBRACE) begin
          h_cnt = 2'd1;
          h_ev0 = EV_CLOSE;
          h_st  = ST_OUT;
        end else begin
          h_cnt = 2'd1;
          h_ev0 = EV_KEY;
          h_ch  = held_q;
        end
      end
      ST_PRE: begin
        if (!is_ws(held_q)) begin
          h_cnt = 2'd1;
          h_ev0 = EV_VALUE;
          h_ch  = held_q;
          h_st  = ST_VAL;
        end
      end
      ST_VAL: begin
        if (held_q == CH_SEMI) begin
          h_cnt = 2'd1;
          h_ev0 = EV_COMMIT;
          h_st  = ST_KEY;
        end else if (held_q == CH_RBRACE) begin
          h_cnt = 2'd2;
          h_ev0 = EV_COMMIT;
          h_ev1 = EV_CLOSE;
          h_st  = ST_OUT;
        end else begin
          h_cnt = 2'd1;
          h_ev0 = EV_VALUE;
          h_ch  = held_q;
        end
      end
      default: begin
        h_st = st_q;
      end
    endcase
    if (!held_vld_q) begin
      h_cnt = 2'd0;
      h_ch  = 8'd0;
      h_st  = st_q;
      took  = 1'b0;
    end
  end

  // assemble the bundle, appending the end event on an end item
  always_comb begin
    b.cnt = h_cnt;
    b.ev0 = h_ev0;
    b.ev1 = h_ev1;
    b.ev2 = EV_END;
    b.ch  = h_ch;
    if (kind_i == KIND_END) begin
      b.cnt = h_cnt + 2'd1;
      case (h_cnt)
        2'd0:    begin
          b.ev0 = EV_END;
          b.ch  = 8'd0;
        end
        2'd1:    b.ev1 = EV_END;
        default: b.ev2 = EV_END;
      endcase
    end
  end

  assign bundle_o = b;
  assign push_o   = accept && (b.cnt != 2'd0);

  // next parse state and lookahead byte
  always_comb begin
    st_d       = st_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    if (kind_i == KIND_END) begin
      st_d       = ST_OUT;
      held_d     = 8'd0;
      held_vld_d = 1'b0;
    end else begin
      st_d = h_st;
      if (took) begin
        held_d     = 8'd0;
        held_vld_d = 1'b0;
      end else begin
        held_d     = char_i;
        held_vld_d = 1'b1;
      end
    end
  end

  // state registers, updated per accepted transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_OUT;
      held_q     <= 8'd0;
      held_vld_q <= 1'b0;
    end else if (accept) begin
      st_q       <= st_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sst_queue.sv =====
// small flop-based queue of event bundles between front and back end
`default_nettype none

module sst_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  sst_pkg::bundle_t      push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output sst_pkg::bundle_t      head_o
);
  import sst_pkg::*;

  bundle_t           mem_q [QDEPTH];
  logic [QAW-1:0]    wptr_q, rptr_q;
  logic [QCW-1:0]    cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

// ===== rtl/core/sst_back.sv =====
// back end: expands bundles into single events into the output register
`default_nettype none

module sst_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  sst_pkg::bundle_t     head_i,
  output logic                 pop_o,
  output logic                 m_tvalid_o,
  input  wire logic            m_tready_i,
  output logic [7:0]           m_tdata_o,
  output logic [2:0]           m_tuser_o,
  output logic                 m_tlast_o
);
  import sst_pkg::*;

  logic [1:0] idx_q;
  logic       vld_q;
  logic [7:0] data_q;
  event_e     ev_q, sel_ev;
  logic       last_q, sel_last, load, take;
  logic [7:0] sel_ch;

  // pick the event at the current index of the head bundle
  always_comb begin
    case (idx_q)
      2'd0:    begin
        sel_ev = head_i.ev0;
        sel_ch = head_i.ch;
      end
      2'd1:    begin
        sel_ev = head_i.ev1;
        sel_ch = 8'd0;
      end
      default: begin
        sel_ev = head_i.ev2;
        sel_ch = 8'd0;
      end
    endcase
    sel_last = (idx_q == head_i.cnt - 2'd1);
  end

  assign load  = !vld_q || m_tready_i;
  assign take  = load && !empty_i;
  assign pop_o = take && sel_last;

  // event index within the head bundle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      if (take) idx_q <= sel_last ? 2'd0 : idx_q + 2'd1;
      if (load) vld_q <= !empty_i;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= sel_ch;
      ev_q   <= sel_ev;
      last_q <= sel_last;
    end
  end

  assign m_tvalid_o = vld_q;
  assign m_tdata_o  = data_q;
  assign m_tuser_o  = ev_q;
  assign m_tlast_o  = last_q;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the style-sheet tokenizer stream block
`default_nettype none

module testbench;
  import sst_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 1000;
  localparam int PHASE_ITEMS = 105;

  // parser states of the prediction
  typedef enum logic [2:0] {
    PS_OUT       = 3'd0,
    PS_LINE_CMT  = 3'd1,
    PS_BLOCK_CMT = 3'd2,
    PS_NAME      = 3'd3,
    PS_KEY       = 3'd4,
    PS_PRE_VALUE = 3'd5,
    PS_VALUE     = 3'd6
  } parse_e;

  typedef struct {
    event_e     ev;
    logic [7:0] ch;
    logic       last;
  } token_t;

  // predicts token events per accepted item and checks the event stream
  class event_scoreboard;
    parse_e     pstate;
    logic [7:0] held;
    bit         held_ok;
    token_t     expected_events[$];
    int         failures;

    function new();
      pstate   = PS_OUT;
      held     = 8'h00;
      held_ok  = 1'b0;
      failures = 0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function void push(event_e ev, logic [7:0] ch);
      token_t t;
      t.ev   = ev;
      t.ch   = ch;
      t.last = 1'b0;
      expected_events.push_back(t);
    endfunction

    // one byte with optional lookahead; returns whether the lookahead was consumed
    function bit parse_byte(logic [7:0] c, bit has_next, logic [7:0] nx);
      bit took;
      took = 1'b0;
      case (pstate)
        PS_OUT: begin
          if (c == CH_SLASH && has_next && nx == CH_SLASH) begin
            pstate = PS_LINE_CMT;
            took = 1'b1;
          end else if (c == CH_SLASH && has_next && nx == CH_STAR) begin
            pstate = PS_BLOCK_CMT;
            took = 1'b1;
          end else if (!is_blank(c)) begin
            push(EV_NAME, c);
            pstate = PS_NAME;
          end
        end
        PS_LINE_CMT: begin
          if (c == CH_LF) pstate = PS_OUT;
        end
        PS_BLOCK_CMT: begin
          if (c == CH_STAR && has_next && nx == CH_SLASH) begin
            pstate = PS_OUT;
            took = 1'b1;
          end
        end
        PS_NAME: begin
          if (!is_blank(c)) begin
            if (c == CH_LBRACE) begin
              push(EV_OPEN, 8'h00);
              pstate = PS_KEY;
            end else begin
              push(EV_NAME, c);
            end
          end
        end
        PS_KEY: begin
          if (!is_blank(c)) begin
            if (c == CH_COLON) begin
              pstate = PS_PRE_VALUE;
            end else if (c == CH_RBRACE) begin
              push(EV_CLOSE, 8'h00);
              pstate = PS_OUT;
            end else begin
              push(EV_KEY, c);
            end
          end
        end
        PS_PRE_VALUE: begin
          if (!is_blank(c)) begin
            push(EV_VALUE, c);
            pstate = PS_VALUE;
          end
        end
        PS_VALUE: begin
          if (c == CH_SEMI) begin
            push(EV_COMMIT, 8'h00);
            pstate = PS_KEY;
          end else if (c == CH_RBRACE) begin
            push(EV_COMMIT, 8'h00);
            push(EV_CLOSE, 8'h00);
            pstate = PS_OUT;
          end else begin
            push(EV_VALUE, c);
          end
        end
        default: ;
      endcase
      return took;
    endfunction

    // note an accepted input transfer
    function void predict_item(kind_e k, logic [7:0] c);
      int     n_before;
      bit     took;
      token_t t;
      n_before = expected_events.size();
      if (k == KIND_BYTE) begin
        if (held_ok) begin
          took = parse_byte(held, 1'b1, c);
          if (took) begin
            held_ok = 1'b0;
            held = 8'h00;
          end else begin
            held = c;
          end
        end else begin
          held = c;
          held_ok = 1'b1;
        end
      end else begin
        if (held_ok) took = parse_byte(held, 1'b0, 8'h00);
        push(EV_END, 8'h00);
        pstate  = PS_OUT;
        held    = 8'h00;
        held_ok = 1'b0;
      end
      // mark the final event of this item
      if (expected_events.size() > n_before) begin
        t = expected_events.pop_back();
        t.last = 1'b1;
        expected_events.push_back(t);
      end
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    // compare an accepted output transfer with the oldest expectation
    function void check_event(logic [2:0] ev, logic [7:0] ch, logic lst);
      token_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected event %0d char %02h last %0b", ev, ch, lst));
        return;
      end
      want = expected_events.pop_front();
      if (want.ev !== ev || want.ch !== ch || want.last !== lst)
        report($sformatf({"event mismatch: expected ev %0d ch %02h last %0b, ",
                          "got ev %0d ch %02h last %0b"},
                         want.ev, want.ch, want.last, ev, ch, lst));
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       s_tvalid_i;
  logic       s_tready_o;
  logic [7:0] s_tdata_i;
  logic       s_tuser_i;
  logic       m_tvalid_o;
  logic       m_tready_i;
  logic [7:0] m_tdata_o;
  logic [2:0] m_tuser_o;
  logic       m_tlast_o;

  event_scoreboard board;
  int idle_pct;
  int stall_pct;
  int items_sent;
  int cycle_cnt;

  style_sheet_tokenizer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) board.check_event(m_tuser_o, m_tdata_o, m_tlast_o);
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("style_sheet_tokenizer: mismatch");
      $finish;
    end
  end

  // one input transfer with random idle cycles ahead of it
  task automatic send_item(kind_e k, logic [7:0] c);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= k;
    s_tdata_i  <= c;
    do @(posedge clk_i); while (!s_tready_o);
    board.predict_item(k, c);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] c);
    send_item(KIND_BYTE, c);
  endtask

  // end of text, with a random byte that must be ignored
  task automatic send_end();
    send_item(KIND_END, 8'($urandom_range(255)));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] special_char();
    case ($urandom_range(9))
      0: return CH_SLASH;
      1: return CH_STAR;
      2: return CH_LBRACE;
      3: return CH_RBRACE;
      4: return CH_COLON;
      5: return CH_SEMI;
      default: return blank_char();
    endcase
  endfunction

  // mostly letters, now and then any byte
  function automatic logic [7:0] word_char();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  task automatic maybe_blank();
    if ($urandom_range(3) == 0) send_byte(blank_char());
  endtask

  // a well-formed style with random content, sometimes cut short by end of text
  task automatic emit_style();
    int n_attr;
    int n_len;
    bit closed;
    closed = 1'b0;
    n_len = 1 + $urandom_range(4);
    for (int i = 0; i < n_len; i++) begin
      send_byte(word_char());
      if ($urandom_range(5) == 0) send_byte(blank_char());
    end
    maybe_blank();
    send_byte(CH_LBRACE);
    n_attr = $urandom_range(3);
    for (int a = 0; a < n_attr; a++) begin
      maybe_blank();
      n_len = 1 + $urandom_range(3);
      for (int i = 0; i < n_len; i++) send_byte(word_char());
      maybe_blank();
      send_byte(CH_COLON);
      maybe_blank();
      n_len = 1 + $urandom_range(4);
      for (int i = 0; i < n_len; i++) begin
        send_byte(word_char());
        if ($urandom_range(4) == 0) send_byte(blank_char());
      end
      if ($urandom_range(9) == 0) begin
        send_end();
        return;
      end
      if (a == n_attr - 1 && $urandom_range(1) == 0) begin
        send_byte(CH_RBRACE);
        closed = 1'b1;
      end else begin
        send_byte(CH_SEMI);
      end
    end
    if (!closed) begin
      maybe_blank();
      send_byte(CH_RBRACE);
    end
    maybe_blank();
  endtask

  // stimulus phases and final check
  initial begin
    int drain;
    rst_ni     = 1'b0;
    s_tvalid_i = 1'b0;
    s_tuser_i  = 1'b0;
    s_tdata_i  = 8'h00;
    m_tready_i = 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    items_sent = 0;
    board = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 45;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 45;
        end
        default: begin
          idle_pct  = 31;
          stall_pct = 31;
        end
      endcase
      while (items_sent < (p + 1) * PHASE_ITEMS) begin
        case ($urandom_range(11))
          0: send_text("/* note * / x */");
          1: send_text("// line note\n");
          2: send_byte(special_char());
          3: send_end();
          4: send_byte(8'($urandom_range(255)));
          default: emit_style();
        endcase
      end
    end
    send_end();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    stall_pct = 0;
    drain = 0;
    while (board.expected_events.size() != 0 && drain < DRAIN_CYCLES) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    if (board.failures == 0 && board.expected_events.size() == 0)
      $display("style_sheet_tokenizer: match");
    else
      $display("style_sheet_tokenizer: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/sst_pkg.sv
rtl/core/sst_front.sv
rtl/core/sst_queue.sv
rtl/core/sst_back.sv
rtl/core/style_sheet_tokenizer.sv
dv/testbench.sv
